>>> rtl/pinhole_camera_ray_generator_core_defines.svh
// Assertion macros used by the ray generator top level
`ifndef PINHOLE_CAMERA_RAY_GENERATOR_CORE_DEFINES_SVH
`define PINHOLE_CAMERA_RAY_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst
`define PCRG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst
`define PCRG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/pcrg_pkg.sv
// Shared types, widths, codes and helpers of the ray generator
`default_nettype none
package pcrg_pkg;

  localparam int FRAC_BITS = 14;
  localparam int PIX_W     = 12;
  localparam int COMP_W    = 16;
  localparam int TAN_W     = 24;
  localparam int DIM_W     = 13;
  localparam int IDX_W     = 3;
  localparam int CFG_W     = 24;

  localparam int WIDE_W = 54;                  // signed direction sum
  localparam int MAG_W  = 30;                  // normalized magnitude
  localparam int SUM_W  = 2 * MAG_W + 2;       // sum of three squares
  localparam int RES_W  = SUM_W + 1;           // square-root work register
  localparam int LEN_W  = MAG_W + 1;           // vector length
  localparam int QUO_W  = FRAC_BITS + 1;       // unit component magnitude
  localparam int REM_W  = MAG_W + FRAC_BITS + 2;
  localparam int SQRT_STEPS = SUM_W / 2;

  localparam logic [IDX_W-1:0] REG_FWD_X        = 3'd0;
  localparam logic [IDX_W-1:0] REG_FWD_Y        = 3'd1;
  localparam logic [IDX_W-1:0] REG_FWD_Z        = 3'd2;
  localparam logic [IDX_W-1:0] REG_HALF_FOV_TAN = 3'd3;
  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd4;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd5;

  localparam logic [13:0] UP_SWITCH_SCALE = 14'd10000;
  localparam logic [30:0] UP_SWITCH_LIMIT = 31'(9999 << FRAC_BITS);

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  typedef struct packed {
    logic  valid;
    logic  basis;
    wide_t x;
    wide_t y;
    wide_t z;
  } norm_req_t;

  typedef struct packed {
    logic  valid;
    logic  basis;
    logic  zero;
    comp_t x;
    comp_t y;
    comp_t z;
  } norm_rsp_t;

  typedef struct packed {
    logic  ready;
    logic  deg;
    comp_t rx;
    comp_t ry;
    comp_t rz;
    comp_t ux;
    comp_t uy;
    comp_t uz;
  } basis_t;

  typedef struct packed {
    logic       valid;
    logic       basis;
    logic       zero;
    logic [2:0] neg;
  } nctl_t;

  typedef struct packed {
    nctl_t                  ctl;
    logic [WIDE_W-1:0]      mx;
    logic [2:0][WIDE_W-1:0] m;
  } nshift_t;

  function automatic wide_t widen17(input logic signed [16:0] v);
    return {{(WIDE_W-17){v[16]}}, v};
  endfunction

  function automatic wide_t widen33(input logic signed [32:0] v);
    return {{(WIDE_W-33){v[32]}}, v};
  endfunction

  // Shift right by s when the largest magnitude sits at or above bit MAG_W-1+s
  function automatic nshift_t shr_step(input nshift_t v, input int unsigned s);
    nshift_t o;
    o = v;
    if ((v.mx >> (MAG_W - 1 + s)) != '0) begin
      o.mx = v.mx >> s;
      for (int i = 0; i < 3; i++) begin
        o.m[i] = v.m[i] >> s;
      end
    end
    return o;
  endfunction

  // Shift left by s when the largest magnitude sits below bit MAG_W-s
  function automatic nshift_t shl_step(input nshift_t v, input int unsigned s);
    nshift_t o;
    o = v;
    if ((v.mx >> (MAG_W - s)) == '0) begin
      o.mx = v.mx << s;
      for (int i = 0; i < 3; i++) begin
        o.m[i] = v.m[i] << s;
      end
    end
    return o;
  endfunction

endpackage
`default_nettype wire

>>> rtl/pcrg_norm.sv
// Pipelined 3-vector normalizer: scale, square sum, square root, divide
`default_nettype none
module pcrg_norm (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire pcrg_pkg::norm_req_t req,
  output pcrg_pkg::norm_rsp_t     rsp
);
  import pcrg_pkg::*;

  typedef struct packed {
    nctl_t                 ctl;
    logic [2:0][MAG_W-1:0] m;
  } ncarry_t;

  typedef struct packed {
    nctl_t                 ctl;
    logic [LEN_W-1:0]      len;
    logic [2:0][REM_W-1:0] rem;
    logic [2:0][QUO_W-1:0] q;
  } ndiv_t;

  // magnitudes and largest magnitude
  nshift_t a_next, a_reg, b_reg, c_reg, d_reg, e_reg;
  logic [2:0][WIDE_W-1:0] v_in;

  always_comb begin
    v_in = {req.z, req.y, req.x};
    a_next.ctl.valid = req.valid;
    a_next.ctl.basis = req.basis;
    for (int i = 0; i < 3; i++) begin
      a_next.ctl.neg[i] = v_in[i][WIDE_W-1];
      a_next.m[i] = v_in[i][WIDE_W-1] ? (WIDE_W'(0) - v_in[i]) : v_in[i];
    end
    a_next.mx = a_next.m[0];
    if (a_next.m[1] > a_next.mx) a_next.mx = a_next.m[1];
    if (a_next.m[2] > a_next.mx) a_next.mx = a_next.m[2];
    a_next.ctl.zero = (a_next.mx == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_reg.ctl.valid <= 1'b0;
      b_reg.ctl.valid <= 1'b0;
      c_reg.ctl.valid <= 1'b0;
      d_reg.ctl.valid <= 1'b0;
      e_reg.ctl.valid <= 1'b0;
    end else if (en) begin
      a_reg <= a_next;
      b_reg <= shr_step(shr_step(a_reg, 16), 8);
      c_reg <= shr_step(shr_step(shr_step(b_reg, 4), 2), 1);
      d_reg <= shl_step(shl_step(c_reg, 16), 8);
      e_reg <= shl_step(shl_step(shl_step(d_reg, 4), 2), 1);
    end
  end

  // squares, then their sum
  ncarry_t f_reg, g_reg;
  logic [2:0][2*MAG_W-1:0] sq;
  logic [SUM_W-1:0] g_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_reg.ctl.valid <= 1'b0;
      g_reg.ctl.valid <= 1'b0;
    end else if (en) begin
      f_reg.ctl <= e_reg.ctl;
      for (int i = 0; i < 3; i++) begin
        f_reg.m[i] <= e_reg.m[i][MAG_W-1:0];
        sq[i] <= e_reg.m[i][MAG_W-1:0] * e_reg.m[i][MAG_W-1:0];
      end
      g_reg <= f_reg;
      g_sum <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
    end
  end

  // square root, one result bit per stage
  ncarry_t          sc [1:SQRT_STEPS];
  logic [SUM_W-1:0] sn [1:SQRT_STEPS];
  logic [RES_W-1:0] sr [1:SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam int BIT_POS = 2 * (SQRT_STEPS - 1 - k);
    ncarry_t          c_in;
    logic [SUM_W-1:0] n_in;
    logic [RES_W-1:0] r_in;
    logic [RES_W-1:0] trial;
    if (k == 0) begin : g_first
      assign c_in = g_reg;
      assign n_in = g_sum;
      assign r_in = '0;
    end else begin : g_rest
      assign c_in = sc[k];
      assign n_in = sn[k];
      assign r_in = sr[k];
    end
    assign trial = r_in + (RES_W'(1) << BIT_POS);
    always_ff @(posedge clk) begin
      if (rst) begin
        sc[k+1].ctl.valid <= 1'b0;
      end else if (en) begin
        sc[k+1] <= c_in;
        if ({1'b0, n_in} >= trial) begin
          sn[k+1] <= n_in - trial[SUM_W-1:0];
          sr[k+1] <= (r_in >> 1) + (RES_W'(1) << BIT_POS);
        end else begin
          sn[k+1] <= n_in;
          sr[k+1] <= r_in >> 1;
        end
      end
    end
  end

  // rounded division, one quotient bit per stage
  ndiv_t dv [0:QUO_W];
  logic [LEN_W-1:0] root;
  assign root = sr[SQRT_STEPS][LEN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0].ctl.valid <= 1'b0;
    end else if (en) begin
      dv[0].ctl <= sc[SQRT_STEPS].ctl;
      dv[0].len <= root;
      for (int i = 0; i < 3; i++) begin
        dv[0].rem[i] <= (REM_W'(sc[SQRT_STEPS].m[i]) << FRAC_BITS) + REM_W'(root >> 1);
        dv[0].q[i] <= '0;
      end
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    localparam int QBIT = QUO_W - 1 - k;
    logic [REM_W-1:0] cand;
    assign cand = REM_W'(dv[k].len) << QBIT;
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1].ctl.valid <= 1'b0;
      end else if (en) begin
        dv[k+1].ctl <= dv[k].ctl;
        dv[k+1].len <= dv[k].len;
        for (int i = 0; i < 3; i++) begin
          if (dv[k].rem[i] >= cand) begin
            dv[k+1].rem[i] <= dv[k].rem[i] - cand;
            dv[k+1].q[i] <= dv[k].q[i] | (QUO_W'(1) << QBIT);
          end else begin
            dv[k+1].rem[i] <= dv[k].rem[i];
            dv[k+1].q[i] <= dv[k].q[i];
          end
        end
      end
    end
  end

  // restore signs; a zero vector reads as zero
  logic [2:0][COMP_W-1:0] comp;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv[QUO_W].ctl.zero) begin
        comp[i] = '0;
      end else if (dv[QUO_W].ctl.neg[i]) begin
        comp[i] = COMP_W'(0) - {1'b0, dv[QUO_W].q[i]};
      end else begin
        comp[i] = {1'b0, dv[QUO_W].q[i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (en) begin
      rsp.valid <= dv[QUO_W].ctl.valid;
      rsp.basis <= dv[QUO_W].ctl.basis;
      rsp.zero  <= dv[QUO_W].ctl.zero;
      rsp.x     <= comp[0];
      rsp.y     <= comp[1];
      rsp.z     <= comp[2];
    end
  end

endmodule
`default_nettype wire

>>> rtl/pcrg_screen.sv
// Pixel front end: screen offsets and the unnormalized ray direction
`default_nettype none
module pcrg_screen (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         en,
  input  wire logic                         in_valid,
  input  wire logic [pcrg_pkg::PIX_W-1:0]   pixel_x,
  input  wire logic [pcrg_pkg::PIX_W-1:0]   pixel_y,
  input  wire pcrg_pkg::comp_t              fwd_x,
  input  wire pcrg_pkg::comp_t              fwd_y,
  input  wire pcrg_pkg::comp_t              fwd_z,
  input  wire logic [pcrg_pkg::TAN_W-1:0]   half_fov_tan,
  input  wire logic [pcrg_pkg::DIM_W-1:0]   width,
  input  wire logic [pcrg_pkg::DIM_W-1:0]   height,
  input  wire pcrg_pkg::basis_t             basis,
  output pcrg_pkg::norm_req_t               req
);
  import pcrg_pkg::*;

  localparam int OFS_W = DIM_W + 2;
  localparam int FH_W  = COMP_W + 1 + DIM_W;
  localparam int RA_W  = COMP_W + OFS_W;

  // stage 1: offsets and |f| * H
  logic                   s1_valid;
  logic signed [OFS_W-1:0] s1_a, s1_b;
  logic [2:0]             s1_neg;
  logic [2:0][FH_W-1:0]   s1_fh;
  logic [2:0][COMP_W-1:0] f_in;
  logic [2:0][COMP_W:0]   f_mag;

  always_comb begin
    f_in = {fwd_z, fwd_y, fwd_x};
    for (int i = 0; i < 3; i++) begin
      f_mag[i] = f_in[i][COMP_W-1] ? ((COMP_W+1)'(0) - {1'b1, f_in[i]}) : {1'b0, f_in[i]};
    end
  end

  // stage 2: basis times offsets, forward term at the common scale
  logic                         s2_valid;
  logic [2:0][RA_W-1:0]         s2_ra, s2_ub;
  logic [2:0][WIDE_W-1:0]       s2_fw;
  // stage 3: times tan(fov/2)
  logic                         s3_valid;
  logic [2:0][WIDE_W-1:0]       s3_rat, s3_ubt, s3_fw;
  logic [2:0][RA_W+TAN_W:0]     rat_full, ubt_full;
  logic [2:0][COMP_W-1:0]       r_in, u_in;
  logic [2:0][WIDE_W-1:0]       fw_mag;

  always_comb begin
    r_in = {basis.rz, basis.ry, basis.rx};
    u_in = {basis.uz, basis.uy, basis.ux};
    for (int i = 0; i < 3; i++) begin
      fw_mag[i] = WIDE_W'(s1_fh[i]) << 16;
      rat_full[i] = $signed(s2_ra[i]) * $signed({1'b0, half_fov_tan});
      ubt_full[i] = $signed(s2_ub[i]) * $signed({1'b0, half_fov_tan});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      req.valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
      s1_a <= $signed({2'b00, pixel_x, 1'b0}) + OFS_W'(1) - $signed({2'b00, width});
      s1_b <= $signed({2'b00, height}) - $signed({2'b00, pixel_y, 1'b0}) - OFS_W'(1);
      for (int i = 0; i < 3; i++) begin
        s1_neg[i] <= f_in[i][COMP_W-1];
        s1_fh[i] <= f_mag[i] * height;
      end

      s2_valid <= s1_valid;
      for (int i = 0; i < 3; i++) begin
        s2_ra[i] <= $signed(r_in[i]) * $signed(s1_a);
        s2_ub[i] <= $signed(u_in[i]) * $signed(s1_b);
        s2_fw[i] <= s1_neg[i] ? (WIDE_W'(0) - fw_mag[i]) : fw_mag[i];
      end

      s3_valid <= s2_valid;
      for (int i = 0; i < 3; i++) begin
        s3_rat[i] <= rat_full[i][WIDE_W-1:0];
        s3_ubt[i] <= ubt_full[i][WIDE_W-1:0];
        s3_fw[i] <= s2_fw[i];
      end

      req.valid <= s3_valid;
      req.basis <= 1'b0;
      req.x <= s3_fw[0] + s3_rat[0] + s3_ubt[0];
      req.y <= s3_fw[1] + s3_rat[1] + s3_ubt[1];
      req.z <= s3_fw[2] + s3_rat[2] + s3_ubt[2];
    end
  end

endmodule
`default_nettype wire

>>> rtl/pcrg_basis.sv
// Camera basis sequencer: right and up vectors through the shared normalizer
`default_nettype none
module pcrg_basis (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                restart,
  input  wire logic                en,
  input  wire pcrg_pkg::comp_t     fwd_x,
  input  wire pcrg_pkg::comp_t     fwd_y,
  input  wire pcrg_pkg::comp_t     fwd_z,
  input  wire pcrg_pkg::norm_rsp_t rsp,
  output pcrg_pkg::norm_req_t      req,
  output pcrg_pkg::basis_t         basis
);
  import pcrg_pkg::*;

  localparam logic [2:0] ST_ISSUE_R = 3'd0;
  localparam logic [2:0] ST_WAIT_R  = 3'd1;
  localparam logic [2:0] ST_CROSS   = 3'd2;
  localparam logic [2:0] ST_ISSUE_U = 3'd3;
  localparam logic [2:0] ST_WAIT_U  = 3'd4;
  localparam logic [2:0] ST_READY   = 3'd5;

  logic [2:0] state;
  logic       pend;
  logic       deg_r, deg_u;
  comp_t      rx, ry, rz, ux, uy, uz;
  wide_t      uvx, uvy, uvz;
  logic       took_rsp;

  logic [COMP_W:0]        fy_mag;
  logic [30:0]            fy_scaled;
  logic signed [COMP_W:0] fx_e, fy_e, fz_e;
  logic signed [32:0]     cx, cy, cz;
  norm_req_t              rv_req, uv_req;

  always_comb begin
    fx_e = {fwd_x[COMP_W-1], fwd_x};
    fy_e = {fwd_y[COMP_W-1], fwd_y};
    fz_e = {fwd_z[COMP_W-1], fwd_z};
    fy_mag = fwd_y[COMP_W-1] ? ((COMP_W+1)'(0) - fy_e) : fy_e;
    fy_scaled = 31'(fy_mag) * 31'(UP_SWITCH_SCALE);

    rv_req.valid = 1'b1;
    rv_req.basis = 1'b1;
    if (fy_scaled > UP_SWITCH_LIMIT) begin
      // forward nearly vertical: take world z as up
      rv_req.x = widen17((COMP_W+1)'(0) - fy_e);
      rv_req.y = widen17(fx_e);
      rv_req.z = '0;
    end else begin
      rv_req.x = widen17(fz_e);
      rv_req.y = '0;
      rv_req.z = widen17((COMP_W+1)'(0) - fx_e);
    end

    uv_req.valid = 1'b1;
    uv_req.basis = 1'b1;
    uv_req.x = uvx;
    uv_req.y = uvy;
    uv_req.z = uvz;

    // extend every operand first so the products are formed at full width
    cx = 33'(fy_e) * 33'(rz) - 33'(fz_e) * 33'(ry);
    cy = 33'(fz_e) * 33'(rx) - 33'(fx_e) * 33'(rz);
    cz = 33'(fx_e) * 33'(ry) - 33'(fy_e) * 33'(rx);

    req = (state == ST_ISSUE_U) ? uv_req : rv_req;
    req.valid = ((state == ST_ISSUE_R) || (state == ST_ISSUE_U)) && !pend;
    took_rsp = rsp.valid && rsp.basis && en;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ISSUE_R;
      pend <= 1'b0;
    end else begin
      // one basis request in flight at a time; a stale answer only clears pend
      if (req.valid && en) begin
        pend <= 1'b1;
      end else if (took_rsp) begin
        pend <= 1'b0;
      end
      if (restart) begin
        state <= ST_ISSUE_R;
      end else begin
        case (state)
          ST_ISSUE_R: if (req.valid && en) state <= ST_WAIT_R;
          ST_WAIT_R:  if (took_rsp) state <= ST_CROSS;
          ST_CROSS:   state <= ST_ISSUE_U;
          ST_ISSUE_U: if (req.valid && en) state <= ST_WAIT_U;
          ST_WAIT_U:  if (took_rsp) state <= ST_READY;
          ST_READY:   state <= ST_READY;
          default:    state <= ST_ISSUE_R;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_WAIT_R && took_rsp) begin
      rx <= rsp.x;
      ry <= rsp.y;
      rz <= rsp.z;
      deg_r <= rsp.zero;
    end
    if (state == ST_CROSS) begin
      uvx <= widen33(cx);
      uvy <= widen33(cy);
      uvz <= widen33(cz);
    end
    if (state == ST_WAIT_U && took_rsp) begin
      ux <= rsp.x;
      uy <= rsp.y;
      uz <= rsp.z;
      deg_u <= rsp.zero;
    end
  end

  always_comb begin
    basis.ready = (state == ST_READY);
    basis.deg = deg_r | deg_u;
    basis.rx = rx;
    basis.ry = ry;
    basis.rz = rz;
    basis.ux = ux;
    basis.uy = uy;
    basis.uz = uz;
  end

endmodule
`default_nettype wire

>>> rtl/pinhole_camera_ray_generator_core.sv
// Top level of the pinhole camera primary-ray generator
//
//   port group   dir   carries
//   s_*          in    pixel request: tdata = pixel_x, pixel_y
//   m_*          out   ray: tdata = dir_x, dir_y, dir_z; tuser = degenerate
//   cfg_*        in    register writes: forward, tan(fov/2), image size
//
// One pixel per cycle while s_tready is high; each ray passes through the
// 31-stage square root and 15-stage divider of the normalizer.
// After reset and after any register write the camera basis is rebuilt by two
// passes through that normalizer with s_tready low.
// A stalled m_* side holds the pipe only once a ray waits at its last stage.
`default_nettype none
`include "pinhole_camera_ray_generator_core_defines.svh"
module pinhole_camera_ray_generator_core #(
  parameter int MAX_DIM = 4096
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [2*pcrg_pkg::PIX_W-1:0] s_tdata,   // pixel_x, pixel_y
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [3*pcrg_pkg::COMP_W-1:0]    m_tdata,   // dir_x, dir_y, dir_z
  output logic                             m_tuser,   // degenerate
  input  wire logic                        cfg_wen,
  input  wire logic [pcrg_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [pcrg_pkg::CFG_W-1:0]  cfg_data
);
  import pcrg_pkg::*;

  localparam int DIM_MAX_CODE = (1 << DIM_W) - 1;
  localparam int CAP_I = (MAX_DIM > DIM_MAX_CODE) ? DIM_MAX_CODE : MAX_DIM;
  localparam logic [DIM_W-1:0] DIM_CAP = DIM_W'(CAP_I);

  comp_t              fwd_x, fwd_y, fwd_z;
  logic [TAN_W-1:0]   half_fov_tan;
  logic [DIM_W-1:0]   image_width, image_height;
  logic [DIM_W-1:0]   width_c, height_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_x <= '0;
      fwd_y <= '0;
      fwd_z <= COMP_W'(1 << FRAC_BITS);
      half_fov_tan <= TAN_W'(65536);
      image_width <= DIM_W'(640);
      image_height <= DIM_W'(480);
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_FWD_X:        fwd_x <= cfg_data[COMP_W-1:0];
        REG_FWD_Y:        fwd_y <= cfg_data[COMP_W-1:0];
        REG_FWD_Z:        fwd_z <= cfg_data[COMP_W-1:0];
        REG_HALF_FOV_TAN: half_fov_tan <= cfg_data[TAN_W-1:0];
        REG_IMAGE_WIDTH:  image_width <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    width_c = image_width;
    if (image_width == '0) width_c = DIM_W'(1);
    else if (image_width > DIM_CAP) width_c = DIM_CAP;
    height_c = image_height;
    if (image_height == '0) height_c = DIM_W'(1);
    else if (image_height > DIM_CAP) height_c = DIM_CAP;
  end

  logic      en;
  basis_t    bas;
  norm_req_t scr_req, bas_req, nreq;
  norm_rsp_t nrsp;

  // advance unless a finished ray would land on a stalled output register
  assign en = !(nrsp.valid && !nrsp.basis && m_tvalid && !m_tready);
  assign s_tready = en && bas.ready;

  pcrg_screen u_screen (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (s_tvalid && s_tready),
    .pixel_x      (s_tdata[PIX_W-1:0]),
    .pixel_y      (s_tdata[2*PIX_W-1:PIX_W]),
    .fwd_x        (fwd_x),
    .fwd_y        (fwd_y),
    .fwd_z        (fwd_z),
    .half_fov_tan (half_fov_tan),
    .width        (width_c),
    .height       (height_c),
    .basis        (bas),
    .req          (scr_req)
  );

  pcrg_basis u_basis (
    .clk     (clk),
    .rst     (rst),
    .restart (cfg_wen),
    .en      (en),
    .fwd_x   (fwd_x),
    .fwd_y   (fwd_y),
    .fwd_z   (fwd_z),
    .rsp     (nrsp),
    .req     (bas_req),
    .basis   (bas)
  );

  always_comb begin
    nreq = scr_req;
    if (bas_req.valid) nreq = bas_req;
  end

  pcrg_norm u_norm (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .req (nreq),
    .rsp (nrsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (nrsp.valid && !nrsp.basis && en) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (nrsp.valid && !nrsp.basis && en) begin
      m_tdata <= {nrsp.z, nrsp.y, nrsp.x};
      m_tuser <= nrsp.zero | bas.deg;
    end
  end

  `PCRG_ASSERT_NEXT(a_cfg_blocks_input, cfg_wen, !s_tready, "pixel accepted right after a register write")
  `PCRG_ASSERT_NOW(a_basis_rsp_not_ready, nrsp.valid && nrsp.basis, !bas.ready, "basis answer arrived after basis was complete")
  `PCRG_ASSERT_NOW(a_zero_ray_flagged, m_tvalid && (m_tdata == '0), m_tuser, "all-zero ray without degenerate flag")

endmodule
`default_nettype wire
